/* src/vdh_pkg.sv */
package vdh_pkg;

  localparam int MAX_BUCKETS = 1024;
  localparam int MAX_NODES   = 4096;
  localparam int KEY_WORDS   = 8;
  localparam int BKT_W       = $clog2(MAX_BUCKETS);
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int LINK_W      = $clog2(MAX_NODES + 1);
  localparam int CNT_W       = 11;
  localparam int MOD_BITS    = 4;
  localparam int MOD_STEPS   = 32 / MOD_BITS;

  localparam logic [31:0] HASH_SEED = 32'd65521;

  typedef logic [KEY_WORDS-1:0][31:0] key_t;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef struct packed {
    key_t              key;
    logic [31:0]       new_value;
    logic [BKT_W-1:0]  bucket;
  } entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_HEAD,
    B_LINK,
    B_WALK,
    B_CMP,
    B_DONE
  } back_state_t;

  function automatic logic [31:0] word_mult(input int i);
    case (i)
      0:       word_mult = 32'd2;
      1:       word_mult = 32'd3;
      2:       word_mult = 32'd5;
      3:       word_mult = 32'd7;
      4:       word_mult = 32'd11;
      5:       word_mult = 32'd13;
      6:       word_mult = 32'd17;
      default: word_mult = 32'd19;
    endcase
  endfunction

  function automatic logic [31:0] key_hash(input key_t k);
    logic [31:0] h;
    h = HASH_SEED;
    for (int i = 0; i < KEY_WORDS; i++) begin
      h = h ^ (k[i] * word_mult(i));
    end
    key_hash = h;
  endfunction

endpackage

/* src/vdh_front.sv */
module vdh_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  vdh_pkg::key_t         key_i,
  input  logic [31:0]           new_value_i,
  input  logic                  cfg_we,
  input  logic [10:0]           cfg_wdata,
  input  logic                  back_ready_i,
  output logic                  q_push_o,
  input  logic                  q_full_i,
  output vdh_pkg::entry_t       q_data_o
);
  import vdh_pkg::*;

  front_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]   bucket_cnt_r;
  logic [CNT_W-1:0]   divisor;
  key_t               key_r;
  logic [31:0]        newv_r;
  logic [31:0]        hash_r, hash_nxt;
  logic [BKT_W-1:0]   rem_r, rem_nxt;
  logic [$clog2(MOD_STEPS)-1:0] step_r;
  logic               accept;

  assign full   = (state_r != F_IDLE) || !back_ready_i;
  assign accept = push && !full;

  always_comb begin
    if (bucket_cnt_r == '0) begin
      divisor = CNT_W'(1);
    end else if (bucket_cnt_r > CNT_W'(MAX_BUCKETS)) begin
      divisor = CNT_W'(MAX_BUCKETS);
    end else begin
      divisor = bucket_cnt_r;
    end
  end

  // restoring remainder, MOD_BITS hash bits per cycle, msb first
  always_comb begin
    logic [CNT_W:0] t;
    t = {{(CNT_W+1-BKT_W){1'b0}}, rem_r};
    for (int i = 0; i < MOD_BITS; i++) begin
      t = {t[CNT_W-1:0], hash_r[31-i]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
    end
    rem_nxt  = t[BKT_W-1:0];
    hash_nxt = hash_r << MOD_BITS;
  end

  always_comb begin
    state_nxt = state_r;
    q_push_o  = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_MOD;
        end
      end
      F_MOD: begin
        if (step_r == $bits(step_r)'(MOD_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o  = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign q_data_o = '{key: key_r, new_value: newv_r, bucket: rem_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      bucket_cnt_r <= CNT_W'(MAX_BUCKETS);
      step_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        bucket_cnt_r <= cfg_wdata;
      end
      if (state_r == F_MOD) begin
        step_r <= step_r + 1'b1;
      end else begin
        step_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r  <= key_i;
      newv_r <= new_value_i;
      hash_r <= key_hash(key_i);
      rem_r  <= '0;
    end else if (state_r == F_MOD) begin
      hash_r <= hash_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

/* src/vdh_queue.sv */
module vdh_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  vdh_pkg::entry_t  din,
  input  logic             pop,
  output logic             empty,
  output vdh_pkg::entry_t  dout
);
  import vdh_pkg::*;

  entry_t      slot_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign dout  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* src/vdh_back.sv */
module vdh_back (
  input  logic               clk,
  input  logic               rst_n,
  output logic               ready_o,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  input  vdh_pkg::entry_t    q_data_i,
  output logic               empty,
  input  logic               pop,
  output logic [31:0]        out_value,
  output logic [1:0]         out_status
);
  import vdh_pkg::*;

  back_state_t        state_r, state_nxt;
  logic [BKT_W:0]     clr_cnt_r;
  entry_t             ent_r;
  logic [LINK_W-1:0]  link_r, head_r;
  logic [LINK_W-1:0]  steps_r, used_r;
  logic [31:0]        res_value_r;
  status_t            res_status_r;
  logic               out_valid_r;
  logic [31:0]        out_value_r;
  status_t            out_status_r;

  logic [LINK_W-1:0]  heads_mem [MAX_BUCKETS];
  key_t               key_mem   [MAX_NODES];
  logic [31:0]        val_mem   [MAX_NODES];
  logic [LINK_W-1:0]  link_mem  [MAX_NODES];

  logic [LINK_W-1:0]  head_q, link_q;
  key_t               key_q;
  logic [31:0]        val_q;

  logic [LINK_W-1:0]  link_m1;
  logic               walk_more, pool_full, do_insert;
  logic               out_load;

  assign ready_o    = (state_r != B_CLEAR);
  assign empty      = !out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign link_m1    = link_r - 1'b1;
  assign walk_more  = (link_r != '0) && (link_r <= LINK_W'(MAX_NODES)) && (steps_r < used_r);
  assign pool_full  = (used_r >= LINK_W'(MAX_NODES));
  assign do_insert  = (state_r == B_WALK) && !walk_more && !pool_full;
  assign out_load   = (state_r == B_DONE) && (!out_valid_r || pop);

  always_comb begin
    state_nxt = state_r;
    q_pop_o   = 1'b0;
    case (state_r)
      B_CLEAR: begin
        if (clr_cnt_r == (BKT_W+1)'(MAX_BUCKETS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          state_nxt = B_HEAD;
        end
      end
      B_HEAD:  state_nxt = B_LINK;
      B_LINK:  state_nxt = B_WALK;
      B_WALK:  state_nxt = walk_more ? B_CMP : B_DONE;
      B_CMP:   state_nxt = (key_q == ent_r.key) ? B_DONE : B_WALK;
      B_DONE: begin
        if (out_load) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (do_insert) begin
        used_r <= used_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      ent_r <= q_data_i;
    end
    if (state_r == B_LINK) begin
      link_r  <= head_q;
      head_r  <= head_q;
      steps_r <= '0;
    end
    if (state_r == B_CMP) begin
      link_r  <= link_q;
      steps_r <= steps_r + 1'b1;
      if (key_q == ent_r.key) begin
        res_value_r  <= val_q;
        res_status_r <= ST_FOUND;
      end
    end
    if (state_r == B_WALK && !walk_more) begin
      if (pool_full) begin
        res_value_r  <= '0;
        res_status_r <= ST_FULL;
      end else begin
        res_value_r  <= ent_r.new_value;
        res_status_r <= ST_INSERTED;
      end
    end
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  // bucket heads: cleared by sweep after reset
  always_ff @(posedge clk) begin
    if (state_r == B_CLEAR) begin
      heads_mem[clr_cnt_r[BKT_W-1:0]] <= '0;
    end else if (do_insert) begin
      heads_mem[ent_r.bucket] <= used_r + 1'b1;
    end
    head_q <= heads_mem[ent_r.bucket];
  end

  // node pool
  always_ff @(posedge clk) begin
    if (do_insert) begin
      key_mem[used_r[NODE_W-1:0]]  <= ent_r.key;
      val_mem[used_r[NODE_W-1:0]]  <= ent_r.new_value;
      link_mem[used_r[NODE_W-1:0]] <= head_r;
    end
    key_q  <= key_mem[link_m1[NODE_W-1:0]];
    val_q  <= val_mem[link_m1[NODE_W-1:0]];
    link_q <= link_mem[link_m1[NODE_W-1:0]];
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= LINK_W'(MAX_NODES))
    else $error("node pool count beyond capacity");

  a_insert_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> used_r == $past(used_r) + 1'b1)
    else $error("node pool count did not advance on insert");

  a_out_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_FOUND || out_status_r == ST_INSERTED ||
                     out_status_r == ST_FULL))
    else $error("bad result status");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> out_value_r == '0)
    else $error("table full result carries nonzero value");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_CLEAR |-> !q_pop_o && !out_valid_r)
    else $error("transaction during head clear");
`endif

endmodule

/* src/vertex_dedup_hash_map_unit.sv */
// channel | handshake      | payload
// input   | in_push/in_full| in_pos_x..in_norm_z, in_new_value
// result  | out_pop/empty  | out_value, out_status
// config  | cfg_we         | cfg_wdata (bucket_count)
//
// Front: hash registered on accept, remainder 4 bits per cycle, then queue push.
// Back: head fetch (HEAD, LINK states), per chain node visited a registered pool
// read then compare (WALK, CMP), then DONE loads the result register.
// After reset the bucket head memory is swept with in_full held high.
// Front and back overlap through a two-entry queue; out_empty low holds a
// result until popped while the next transaction is already walked.
module vertex_dedup_hash_map_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  output logic         in_full,
  input  logic [31:0]  in_pos_x,
  input  logic [31:0]  in_pos_y,
  input  logic [31:0]  in_pos_z,
  input  logic [31:0]  in_tex_u,
  input  logic [31:0]  in_tex_v,
  input  logic [31:0]  in_norm_x,
  input  logic [31:0]  in_norm_y,
  input  logic [31:0]  in_norm_z,
  input  logic [31:0]  in_new_value,
  output logic         out_empty,
  input  logic         out_pop,
  output logic [31:0]  out_value,
  output logic [1:0]   out_status,
  input  logic         cfg_we,
  input  logic [10:0]  cfg_wdata
);
  import vdh_pkg::*;

  key_t    key;
  entry_t  fq_data, qb_data;
  logic    q_push, q_full, q_pop, q_empty, back_ready;

  assign key = {in_norm_z, in_norm_y, in_norm_x, in_tex_v,
                in_tex_u, in_pos_z, in_pos_y, in_pos_x};

  vdh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push),
    .full         (in_full),
    .key_i        (key),
    .new_value_i  (in_new_value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .back_ready_i (back_ready),
    .q_push_o     (q_push),
    .q_full_i     (q_full),
    .q_data_o     (fq_data)
  );

  vdh_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .din   (fq_data),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (qb_data)
  );

  vdh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ready_o    (back_ready),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .q_data_i   (qb_data),
    .empty      (out_empty),
    .pop        (out_pop),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule
